// ===== rtl/core/link_bringup_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// Link bring-up sequencer: assertion macros
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LINK_BRINGUP_SEQUENCER_DEFINES_SVH
`define LINK_BRINGUP_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
`define LBS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("link bring-up sequencer check failed");
`define LBS_ASSERT_IMPL(label, ante, cons) \
  `LBS_ASSERT(label, (ante) |-> (cons))
`else
`define LBS_ASSERT(label, prop)
`define LBS_ASSERT_IMPL(label, ante, cons)
`endif

`endif

// ===== rtl/core/lbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Link bring-up sequencer package
// Phase, status and command codes, register indexes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package lbs_pkg;

  localparam int unsigned TimeW = 32;

  // phase codes
  localparam logic [2:0] PH_CONFIG      = 3'd0;
  localparam logic [2:0] PH_WAIT_CONN   = 3'd1;
  localparam logic [2:0] PH_WAIT_PAIR   = 3'd2;
  localparam logic [2:0] PH_TRANSPARENT = 3'd3;
  localparam logic [2:0] PH_WAIT_TRANSP = 3'd4;
  localparam logic [2:0] PH_LINKED      = 3'd5;

  // module status codes
  localparam logic [1:0] ST_IDLE      = 2'd0;
  localparam logic [1:0] ST_CONNECTED = 2'd1;
  localparam logic [1:0] ST_TRANSP    = 2'd2;

  // command codes
  localparam logic [1:0] CMD_NONE      = 2'd0;
  localparam logic [1:0] CMD_AUTOCONN  = 2'd1;
  localparam logic [1:0] CMD_RESET     = 2'd2;
  localparam logic [1:0] CMD_TRANSP_EN = 2'd3;

  // register indexes
  localparam logic [1:0] REG_CONNECT_TO = 2'd0;
  localparam logic [1:0] REG_PAIR_TO    = 2'd1;
  localparam logic [1:0] REG_TRANSP_TO  = 2'd2;

  localparam logic [TimeW-1:0] CONNECT_TO_RST = 32'd60000;
  localparam logic [TimeW-1:0] PAIR_TO_RST    = 32'd10000;
  localparam logic [TimeW-1:0] TRANSP_TO_RST  = 32'd5000;

  typedef struct packed {
    logic [TimeW-1:0] connect_to;
    logic [TimeW-1:0] pair_to;
    logic [TimeW-1:0] transp_to;
  } lbs_limits_t;

  typedef struct packed {
    logic [2:0]       phase;
    logic [TimeW-1:0] wait_start;
    logic             green;
  } lbs_state_t;

  typedef struct packed {
    logic       green;
    logic       enabled;
    logic [2:0] phase;
    logic [1:0] command;
  } lbs_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/lbs_cfg.sv =====
// ----------------------------------------------------------------------------
// Link bring-up sequencer: timeout registers
// Three wait limits, written one transaction at a time; unknown index ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module lbs_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_valid,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [lbs_pkg::TimeW-1:0]  cfg_data,
  output lbs_pkg::lbs_limits_t            limits
);
  import lbs_pkg::*;

  lbs_limits_t limits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.connect_to <= CONNECT_TO_RST;
      limits_r.pair_to    <= PAIR_TO_RST;
      limits_r.transp_to  <= TRANSP_TO_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CONNECT_TO: limits_r.connect_to <= cfg_data;
        REG_PAIR_TO:    limits_r.pair_to    <= cfg_data;
        REG_TRANSP_TO:  limits_r.transp_to  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign limits = limits_r;

endmodule

`default_nettype wire

// ===== rtl/core/lbs_step.sv =====
// ----------------------------------------------------------------------------
// Link bring-up sequencer: poll step
// Next phase, wait start, indicator and command for one poll.
// ----------------------------------------------------------------------------
`default_nettype none

module lbs_step (
  input  wire logic [lbs_pkg::TimeW-1:0] now_ms,
  input  wire logic [1:0]                module_status,
  input  wire logic                      paired,
  input  wire lbs_pkg::lbs_limits_t      limits,
  input  wire lbs_pkg::lbs_state_t       cur,
  output lbs_pkg::lbs_state_t            nxt,
  output lbs_pkg::lbs_result_t           res
);
  import lbs_pkg::*;

  logic [2:0]       phase_in;
  logic             green_in;
  logic [TimeW-1:0] limit;
  logic [TimeW-1:0] elapsed;
  logic             expired;
  logic [1:0]       cmd;

  // idle status drops back to the start before the phase is handled
  always_comb begin
    phase_in = (module_status == ST_IDLE) ? PH_CONFIG : cur.phase;
    green_in = (module_status == ST_IDLE) ? 1'b0 : cur.green;
  end

  always_comb begin
    unique case (phase_in)
      PH_WAIT_CONN: limit = limits.connect_to;
      PH_WAIT_PAIR: limit = limits.pair_to;
      default:      limit = limits.transp_to;
    endcase
    elapsed = now_ms - cur.wait_start;  // wraps modulo 2^32
    expired = (elapsed >= limit);
  end

  always_comb begin
    nxt.phase      = phase_in;
    nxt.wait_start = cur.wait_start;
    nxt.green      = green_in;
    cmd            = CMD_NONE;
    unique case (phase_in)
      PH_WAIT_CONN: begin
        if (module_status == ST_CONNECTED) begin
          nxt.phase      = PH_WAIT_PAIR;
          nxt.wait_start = now_ms;
        end else if (expired) begin
          nxt.phase = PH_CONFIG;
          cmd       = CMD_RESET;
        end
      end
      PH_WAIT_PAIR: begin
        if (paired) begin
          nxt.phase = PH_TRANSPARENT;
        end else if (expired) begin
          nxt.phase = PH_CONFIG;
          cmd       = CMD_RESET;
        end
      end
      PH_TRANSPARENT: begin
        nxt.phase      = PH_WAIT_TRANSP;
        nxt.wait_start = now_ms;
        cmd            = CMD_TRANSP_EN;
      end
      PH_WAIT_TRANSP: begin
        if (module_status == ST_TRANSP) begin
          nxt.phase = PH_LINKED;
          nxt.green = 1'b1;
        end else if (expired) begin
          nxt.phase = PH_CONFIG;
          cmd       = CMD_RESET;
        end
      end
      PH_LINKED: ;
      default: begin
        // start of bring-up, also any unused code
        nxt.phase      = PH_WAIT_CONN;
        nxt.wait_start = now_ms;
        cmd            = CMD_AUTOCONN;
      end
    endcase
  end

  always_comb begin
    res.command = cmd;
    res.phase   = nxt.phase;
    res.enabled = (nxt.phase == PH_LINKED);
    res.green   = nxt.green;
  end

endmodule

`default_nettype wire

// ===== rtl/core/link_bringup_sequencer.sv =====
// ----------------------------------------------------------------------------
// Link bring-up sequencer
// Polled state machine that brings a radio module up to a transparent link.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                Payload
// in_       in   in_tvalid/in_tready      now_ms, module_status, paired
// out_      out  out_tvalid/out_tready    command, link_phase, enabled, green
// cfg_      in   cfg_valid/cfg_ready      register index, 32-bit timeout
//
// A poll transaction passes through the input register, then the result
// register, with the step logic (one 32-bit subtract and compare) between.
// One poll per cycle is sustained unless out_tready stalls the result; the
// phase register updates as each poll moves into the result register, so
// the next poll sees it straight away. A stalled result holds the input
// register; in_tready falls only then. Synchronous active-low reset clears
// the phase, wait start and indicator, and loads the default timeouts.
// ----------------------------------------------------------------------------
`default_nettype none

`include "link_bringup_sequencer_defines.svh"

module link_bringup_sequencer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // [31:0] now_ms, [33:32] module_status, [34] paired, [39:35] zero
  input  wire logic [39:0] in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] command, [4:2] link_phase, [5] enabled, [6] indicator_green, [7] zero
  output logic [7:0]       out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import lbs_pkg::*;

  logic [TimeW-1:0] now_r;
  logic [1:0]       status_r;
  logic             paired_r;
  logic             in_valid_r;
  logic             advance;

  lbs_limits_t      limits;
  lbs_state_t       state_r;
  lbs_state_t       state_nxt;
  lbs_result_t      res_nxt;
  lbs_result_t      res_r;
  logic             out_valid_r;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      now_r    <= in_tdata[31:0];
      status_r <= in_tdata[33:32];
      paired_r <= in_tdata[34];
    end
  end

  lbs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .limits    (limits)
  );

  lbs_step u_step (
    .now_ms        (now_r),
    .module_status (status_r),
    .paired        (paired_r),
    .limits        (limits),
    .cur           (state_r),
    .nxt           (state_nxt),
    .res           (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r.green, res_r.enabled, res_r.phase, res_r.command};

  `LBS_ASSERT(a_phase_legal, state_r.phase <= PH_LINKED)
  `LBS_ASSERT_IMPL(a_reset_to_start, out_valid_r && res_r.command == CMD_RESET,
                   res_r.phase == PH_CONFIG)
  `LBS_ASSERT_IMPL(a_green_only_linked, out_valid_r && res_r.green,
                   res_r.enabled && res_r.phase == PH_LINKED)
  `LBS_ASSERT_IMPL(a_ready_when_drained, !out_valid_r, in_tready)

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link bring-up sequencer testbench
// Drives polls through the stream port with random gaps and back-pressure,
// reprograms the three wait limits between runs of traffic, and checks every
// result against a cycle-free model of the phase machine held in a
// scoreboard.
// ----------------------------------------------------------------------------

import lbs_pkg::*;

class bringup_scoreboard;
  logic [31:0] connect_lim;
  logic [31:0] pair_lim;
  logic [31:0] transp_lim;
  logic [2:0]  link_phase;
  logic [31:0] wait_start;
  logic        green;
  lbs_result_t poll_results_q[$];
  int          errors;

  function new();
    connect_lim = CONNECT_TO_RST;
    pair_lim    = PAIR_TO_RST;
    transp_lim  = TRANSP_TO_RST;
    link_phase  = PH_CONFIG;
    wait_start  = '0;
    green       = 1'b0;
    errors      = 0;
  endfunction

  task report(string what);
    if (errors < 50) $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  function void write_limit(logic [1:0] idx, logic [31:0] val);
    case (idx)
      REG_CONNECT_TO: connect_lim = val;
      REG_PAIR_TO:    pair_lim    = val;
      REG_TRANSP_TO:  transp_lim  = val;
      default: ;
    endcase
  endfunction

  function logic waited_out(logic [31:0] now_ms, logic [31:0] lim);
    logic [31:0] elapsed;
    elapsed = now_ms - wait_start;
    return elapsed >= lim;
  endfunction

  // step the phase machine for one accepted poll and queue its result
  function void take_poll(logic [31:0] now_ms, logic [1:0] st, logic pd);
    lbs_result_t res;
    logic [1:0]  cmd;
    cmd = CMD_NONE;
    if (st == ST_IDLE) begin
      link_phase = PH_CONFIG;
      green      = 1'b0;
    end
    case (link_phase)
      PH_WAIT_CONN: begin
        if (st == ST_CONNECTED) begin
          link_phase = PH_WAIT_PAIR;
          wait_start = now_ms;
        end else if (waited_out(now_ms, connect_lim)) begin
          link_phase = PH_CONFIG;
          cmd        = CMD_RESET;
        end
      end
      PH_WAIT_PAIR: begin
        if (pd) begin
          link_phase = PH_TRANSPARENT;
        end else if (waited_out(now_ms, pair_lim)) begin
          link_phase = PH_CONFIG;
          cmd        = CMD_RESET;
        end
      end
      PH_TRANSPARENT: begin
        link_phase = PH_WAIT_TRANSP;
        cmd        = CMD_TRANSP_EN;
        wait_start = now_ms;
      end
      PH_WAIT_TRANSP: begin
        if (st == ST_TRANSP) begin
          link_phase = PH_LINKED;
          green      = 1'b1;
        end else if (waited_out(now_ms, transp_lim)) begin
          link_phase = PH_CONFIG;
          cmd        = CMD_RESET;
        end
      end
      PH_LINKED: ;
      default: begin
        link_phase = PH_WAIT_CONN;
        cmd        = CMD_AUTOCONN;
        wait_start = now_ms;
      end
    endcase
    res.command = cmd;
    res.phase   = link_phase;
    res.enabled = (link_phase == PH_LINKED);
    res.green   = green;
    poll_results_q.push_back(res);
  endfunction

  task check_result(logic [7:0] data);
    lbs_result_t got;
    lbs_result_t exp;
    if (poll_results_q.size() == 0) begin
      report($sformatf("result %h with no poll outstanding", data));
      return;
    end
    exp = poll_results_q.pop_front();
    got = data[6:0];
    if (got.command !== exp.command)
      report($sformatf("command %h, expected %h", got.command, exp.command));
    if (got.phase !== exp.phase)
      report($sformatf("link_phase %h, expected %h", got.phase, exp.phase));
    if (got.enabled !== exp.enabled)
      report($sformatf("enabled %b, expected %b", got.enabled, exp.enabled));
    if (got.green !== exp.green)
      report($sformatf("indicator_green %b, expected %b", got.green, exp.green));
    if (data[7] !== 1'b0)
      report($sformatf("padding bit %b, expected 0", data[7]));
  endtask

  function int pending();
    return poll_results_q.size();
  endfunction
endclass

module tb_top;

  localparam logic [1:0] ST_OTHER    = 2'd3;
  localparam logic [1:0] REG_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         SEGMENTS    = 7;
  localparam int         SEG_POLLS   = 270;

  logic        clk = 1'b0;
  logic        rst_n;
  logic [39:0] in_tdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  out_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  bringup_scoreboard sb;
  bit          quiet;
  logic [31:0] clock_ms;
  int          cycle_count = 0;

  link_bringup_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("link_bringup_sequencer verification failed");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // result back-pressure
  initial begin
    forever begin
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // valid is left high on return so back-to-back polls never toggle it
  task automatic drive_poll(logic [31:0] now_ms, logic [1:0] st, logic pd);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tdata  <= {5'b0, pd, st, now_ms};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.take_poll(now_ms, st, pd);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_limit(idx, val);
  endtask

  task automatic program_limits(logic [31:0] c, logic [31:0] p, logic [31:0] t);
    write_reg(REG_CONNECT_TO, c);
    write_reg(REG_UNUSED, $urandom);
    write_reg(REG_PAIR_TO, p);
    write_reg(REG_TRANSP_TO, t);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // mostly walks the bring-up sequence, with time steps aimed at the limits
  task automatic random_poll();
    logic [31:0] lim;
    logic [31:0] now_ms;
    logic [1:0]  st;
    logic        pd;
    int unsigned pick;
    case (sb.link_phase)
      PH_WAIT_CONN: lim = sb.connect_lim;
      PH_WAIT_PAIR: lim = sb.pair_lim;
      default:      lim = sb.transp_lim;
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 8)
      now_ms = $urandom;
    else if (pick < 35)
      now_ms = sb.wait_start + lim + $urandom_range(0, 2) - 1;
    else
      now_ms = clock_ms + $urandom_range(0, 24);
    clock_ms = now_ms;
    pd = 1'($urandom_range(0, 1));
    st = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 3) != 0) begin
      case (sb.link_phase)
        PH_WAIT_CONN:   st = $urandom_range(0, 1) ? ST_CONNECTED : ST_OTHER;
        PH_WAIT_PAIR:   st = $urandom_range(0, 1) ? ST_CONNECTED : ST_OTHER;
        PH_WAIT_TRANSP: st = $urandom_range(0, 1) ? ST_TRANSP : 2'($urandom_range(1, 3));
        PH_LINKED:      st = ($urandom_range(0, 15) == 0) ? ST_IDLE :
                             2'($urandom_range(1, 3));
        default:        st = 2'($urandom_range(1, 3));
      endcase
    end
    drive_poll(now_ms, st, pd);
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tdata  <= '0;
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    quiet     = 1'b0;
    clock_ms  = '0;
    sb        = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default limits: each timeout at and just short of its edge, wrapped time,
    // full walk to linked, hold, and idle status knocking it back down
    drive_poll(32'd0,          ST_IDLE,      1'b0);
    drive_poll(32'd59999,      ST_OTHER,     1'b0);
    drive_poll(32'd60000,      ST_OTHER,     1'b1);
    drive_poll(32'd60001,      ST_CONNECTED, 1'b0);
    drive_poll(32'd60002,      ST_CONNECTED, 1'b0);
    drive_poll(32'd70001,      ST_OTHER,     1'b0);
    drive_poll(32'd70002,      ST_TRANSP,    1'b0);
    drive_poll(32'hFFFF_FFF0,  ST_OTHER,     1'b1);
    drive_poll(32'h0000_0010,  ST_CONNECTED, 1'b1);
    drive_poll(32'h0000_0011,  ST_OTHER,     1'b1);
    drive_poll(32'h0000_0012,  ST_OTHER,     1'b0);
    drive_poll(32'd5017,       ST_CONNECTED, 1'b0);
    drive_poll(32'd5018,       ST_OTHER,     1'b0);
    drive_poll(32'hFFFF_FFFF,  ST_OTHER,     1'b0);
    drive_poll(32'h0000_0005,  ST_CONNECTED, 1'b0);
    drive_poll(32'h0000_0006,  ST_IDLE,      1'b1);
    drive_poll(32'h0000_0007,  ST_CONNECTED, 1'b1);
    drive_poll(32'h0000_0008,  ST_TRANSP,    1'b1);
    drive_poll(32'h0000_0009,  ST_OTHER,     1'b0);
    drive_poll(32'h0000_000A,  ST_TRANSP,    1'b0);
    drive_poll(32'h0000_000B,  ST_OTHER,     1'b1);
    drive_poll(32'hFFFF_FFFF,  ST_CONNECTED, 1'b0);
    drive_poll(32'h0000_000C,  ST_IDLE,      1'b0);
    drain();

    for (int s = 0; s < SEGMENTS; s++) begin
      case (s)
        0: program_limits(32'd0, 32'd0, 32'd0);
        1: program_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: program_limits($urandom_range(1, 16), $urandom_range(1, 16),
                          $urandom_range(1, 16));
        3: program_limits($urandom, $urandom, $urandom);
        4: program_limits(32'd1, 32'd0, 32'hFFFF_FFFF);
        5: program_limits(CONNECT_TO_RST, PAIR_TO_RST, TRANSP_TO_RST);
        default: begin
          quiet = 1'b1;
          program_limits($urandom_range(0, 6), $urandom_range(0, 6),
                         $urandom_range(0, 6));
        end
      endcase
      clock_ms = $urandom;
      for (int n = 0; n < SEG_POLLS; n++) random_poll();
      drain();
    end

    if (sb.errors == 0) begin
      $display("link_bringup_sequencer verification clean");
    end else begin
      $display("link_bringup_sequencer verification failed");
    end
    $finish;
  end

endmodule

// ===== link_bringup_sequencer.f =====
+incdir+rtl/core
rtl/core/lbs_pkg.sv
rtl/core/lbs_cfg.sv
rtl/core/lbs_step.sv
rtl/core/link_bringup_sequencer.sv
test/tb_top.sv
